/* hw/rtl/n_queens_first_solution_defines.svh */
// Assertion macros shared by the n-queens search RTL.
// No dependencies; included by modules that carry assertions.
`ifndef N_QUEENS_FIRST_SOLUTION_DEFINES_SVH
`define N_QUEENS_FIRST_SOLUTION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define NQFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define NQFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/nqfs_pkg.sv */
// Shared constants and types for the n-queens first-solution search.
// No dependencies; used by nqfs_cell and n_queens_first_solution.
package nqfs_pkg;

    // Largest board the search handles
    localparam int MaxBoard = 16;
    // Column / row index width
    localparam int ColW     = $clog2(MaxBoard);
    // Counter width able to hold MaxBoard itself
    localparam int CntW     = $clog2(MaxBoard + 1);
    // Diagonal count and index width
    localparam int DiagN    = 2 * MaxBoard - 1;
    localparam int DiagW    = $clog2(DiagN);
    // Board size register width
    localparam int CfgW     = 5;
    // Reset board size
    localparam int SizeRst  = 8;

    typedef logic [ColW-1:0] t_col;

    // Shift command for the column stack
    typedef struct packed {
        logic push;   // shift toward deeper cells, cell 0 takes new column
        logic pop;    // shift toward cell 0
    } t_cell_ctl;

endpackage

/* hw/rtl/nqfs_cell.sv */
// One stage of the queen-column stack: holds one placed column.
// Depends on nqfs_pkg.
module nqfs_cell (
    input  logic               i_clk,
    input  nqfs_pkg::t_cell_ctl i_ctl,
    input  nqfs_pkg::t_col     i_from_left,
    input  nqfs_pkg::t_col     i_from_right,
    output nqfs_pkg::t_col     o_col
);
    import nqfs_pkg::*;

    t_col r_col;
    t_col n_col;

    // Push takes the shallower neighbor, pop the deeper one
    always_comb begin
        n_col = r_col;
        if (i_ctl.push) begin
            n_col = i_from_left;
        end else if (i_ctl.pop) begin
            n_col = i_from_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_col <= n_col;
    end

    assign o_col = r_col;

endmodule

/* hw/rtl/n_queens_first_solution.sv */
// Top level of the n-queens first-solution search.
// Depends on nqfs_pkg, nqfs_cell and n_queens_first_solution_defines.svh.
//
// An item with start_req set launches a depth-first search for the first
// placement of n queens, n being board_size saturated to 16 (size 0 gives
// no result). Each search step tries one candidate column, backtracks one
// row, or makes the final check. Placed columns live in a chain of stack
// cells that shift on each placement and backtrack. The block then emits n
// results, one per row in order, one per cycle when the sink does not
// stall, by shifting the chain toward its deep end. Input stall stays high
// from the accepted start until the last result is taken. board_size may
// be written only while the block is idle.
`include "n_queens_first_solution_defines.svh"

module n_queens_first_solution (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // start channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_start_req,
    // configuration channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [nqfs_pkg::CfgW-1:0] i_cfg_data,
    // result channel
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [3:0]             o_row_index,
    output logic                   o_has_queen,
    output logic [3:0]             o_queen_column,
    output logic                   o_solved,
    output logic                   o_last_row
);
    import nqfs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_OUT    = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [CfgW-1:0]    r_size;
    logic [CntW-1:0]    r_row, n_row;
    logic [CntW-1:0]    r_cand, n_cand;
    logic [MaxBoard-1:0] r_colmask, n_colmask;
    logic [DiagN-1:0]   r_ddmask, n_ddmask;
    logic [DiagN-1:0]   r_dumask, n_dumask;
    logic               r_ok, n_ok;
    t_col               r_out_row, n_out_row;
    logic               r_oval, n_oval;

    logic [CntW-1:0]    w_n;
    t_col               w_n_m1;
    t_col               w_col [MaxBoard];
    t_cell_ctl          w_ctl;
    logic               w_in_acc, w_out_acc;
    logic               w_row_open, w_cand_open, w_free;
    t_col               w_sel_r, w_sel_c;
    logic [DiagW-1:0]   w_dd_idx, w_du_idx;

    // Effective board size, saturated
    always_comb begin
        if (int'(r_size) > MaxBoard) begin
            w_n = CntW'(MaxBoard);
        end else begin
            w_n = CntW'(r_size);
        end
    end
    assign w_n_m1 = ColW'(w_n - CntW'(1));

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_valid && !o_stall;
    assign w_out_acc   = r_oval && !i_stall;

    // Search step decode
    assign w_row_open  = (r_row < w_n);
    assign w_cand_open = (r_cand < w_n);

    // Place being tested, or the one being removed on backtrack
    always_comb begin
        if (w_cand_open) begin
            w_sel_r = r_row[ColW-1:0];
            w_sel_c = r_cand[ColW-1:0];
        end else begin
            w_sel_r = ColW'(r_row - CntW'(1));
            w_sel_c = w_col[0];
        end
    end
    assign w_dd_idx = DiagW'((DiagW+1)'(w_sel_r) + (DiagW+1)'(MaxBoard - 1)
                             - (DiagW+1)'(w_sel_c));
    assign w_du_idx = DiagW'((DiagW+1)'(w_sel_r) + (DiagW+1)'(w_sel_c));
    assign w_free   = !r_colmask[w_sel_c] && !r_ddmask[w_dd_idx] && !r_dumask[w_du_idx];

    // Stack shift commands
    always_comb begin
        w_ctl.push = 1'b0;
        w_ctl.pop  = 1'b0;
        case (r_state)
            S_SEARCH: begin
                w_ctl.push = w_row_open && w_cand_open && w_free;
                w_ctl.pop  = w_row_open && !w_cand_open && (r_row != '0);
            end
            S_OUT: begin
                w_ctl.push = w_out_acc;
            end
            default: ;
        endcase
    end

    // Column stack chain
    genvar k;
    generate
        for (k = 0; k < MaxBoard; k++) begin : g_cell
            t_col w_left, w_right;
            if (k == 0) begin : g_head
                assign w_left = r_cand[ColW-1:0];
            end else begin : g_mid
                assign w_left = w_col[k-1];
            end
            if (k == MaxBoard - 1) begin : g_tail
                assign w_right = w_col[k];
            end else begin : g_body
                assign w_right = w_col[k+1];
            end
            nqfs_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_from_left  (w_left),
                .i_from_right (w_right),
                .o_col        (w_col[k])
            );
        end
    endgenerate

    // Controller next state
    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_cand    = r_cand;
        n_colmask = r_colmask;
        n_ddmask  = r_ddmask;
        n_dumask  = r_dumask;
        n_ok      = r_ok;
        n_out_row = r_out_row;
        n_oval    = r_oval;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_start_req && (w_n != '0)) begin
                    n_state   = S_SEARCH;
                    n_row     = '0;
                    n_cand    = '0;
                    n_colmask = '0;
                    n_ddmask  = '0;
                    n_dumask  = '0;
                end
            end
            S_SEARCH: begin
                if (!w_row_open) begin
                    // full placement found
                    n_ok      = 1'b1;
                    n_state   = S_OUT;
                    n_oval    = 1'b1;
                    n_out_row = '0;
                end else if (w_cand_open) begin
                    if (w_free) begin
                        n_colmask[w_sel_c]  = 1'b1;
                        n_ddmask[w_dd_idx]  = 1'b1;
                        n_dumask[w_du_idx]  = 1'b1;
                        n_row  = r_row + CntW'(1);
                        n_cand = '0;
                    end else begin
                        n_cand = r_cand + CntW'(1);
                    end
                end else if (r_row == '0) begin
                    // search exhausted
                    n_ok      = 1'b0;
                    n_state   = S_OUT;
                    n_oval    = 1'b1;
                    n_out_row = '0;
                end else begin
                    // backtrack: lift the previous row's queen
                    n_colmask[w_sel_c]  = 1'b0;
                    n_ddmask[w_dd_idx]  = 1'b0;
                    n_dumask[w_du_idx]  = 1'b0;
                    n_row  = r_row - CntW'(1);
                    n_cand = CntW'(w_sel_c) + CntW'(1);
                end
            end
            S_OUT: begin
                if (w_out_acc) begin
                    if (r_out_row == w_n_m1) begin
                        n_oval  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_out_row = r_out_row + ColW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                n_oval  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_size    <= CfgW'(SizeRst);
            r_row     <= '0;
            r_cand    <= '0;
            r_colmask <= '0;
            r_ddmask  <= '0;
            r_dumask  <= '0;
            r_oval    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row     <= n_row;
            r_cand    <= n_cand;
            r_colmask <= n_colmask;
            r_ddmask  <= n_ddmask;
            r_dumask  <= n_dumask;
            r_oval    <= n_oval;
            if (i_cfg_valid && o_cfg_ready) begin
                r_size <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ok      <= n_ok;
        r_out_row <= n_out_row;
    end

    // Result: row j sits in cell n-1 after j shifts
    assign o_valid        = r_oval;
    assign o_row_index    = 4'(r_out_row);
    assign o_has_queen    = r_ok;
    assign o_solved       = r_ok;
    assign o_queen_column = r_ok ? 4'(w_col[w_n_m1]) : 4'd0;
    assign o_last_row     = (r_out_row == w_n_m1);

    // Checks
    `NQFS_ASSERT_NOW(a_oval_in_out, i_clk, i_rst_n, r_oval, r_state == S_OUT)
    `NQFS_ASSERT_NOW(a_row_bound, i_clk, i_rst_n, r_state == S_SEARCH, r_row <= w_n)
    `NQFS_ASSERT_NEXT(a_last_to_idle, i_clk, i_rst_n, w_out_acc && o_last_row,
        r_state == S_IDLE && !r_oval)
    `NQFS_ASSERT_NEXT(a_start_search, i_clk, i_rst_n,
        w_in_acc && i_start_req && (w_n != '0), r_state == S_SEARCH)
    `NQFS_ASSERT_NOW(a_no_dual_shift, i_clk, i_rst_n, w_ctl.pop, !w_ctl.push)

endmodule

/* test/tb_n_queens_first_solution.sv */
`timescale 1ns / 100ps
// Self-checking testbench for n_queens_first_solution: start requests over several board sizes.
// Each row result is checked against a search kept in the bench. Depends on nqfs_pkg and the RTL.
module tb_n_queens_first_solution;
    import nqfs_pkg::*;

    localparam int SettleCycles = 64;      // quiet time before a size change and at the end
    localparam int LongHold     = 400;     // long output back-pressure stretch
    localparam int RandomStarts = 80;      // start requests in the random part
    localparam int TimeoutNs    = 1_000_000_000;

    // one row of a reported placement
    typedef struct packed {
        logic [3:0] row;
        logic       has_queen;
        logic [3:0] column;
        logic       solved;
        logic       last;
    } row_report_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            start_valid = 1'b0;
    logic            start_stall;
    logic            start_req = 1'b0;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [CfgW-1:0] cfg_data = '0;
    logic            row_valid;
    logic            row_stall = 1'b0;
    logic [3:0]      row_index;
    logic            has_queen;
    logic [3:0]      queen_column;
    logic            solved;
    logic            last_row;

    // items waiting to be offered, and rows still to come back
    logic            pending_starts[$];
    row_report_t     expected_rows[$];

    logic [CfgW-1:0] size_setting = SizeRst[CfgW-1:0];
    logic            start_taken = 1'b0;
    logic            first_hold_done = 1'b0;
    int              error_count = 0;
    int              searches_run = 0;
    int              idle_items = 0;
    int              rows_checked = 0;
    int              long_holds = 0;
    logic [MaxBoard:0] sizes_seen = '0;

    n_queens_first_solution dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (start_valid),
        .o_stall        (start_stall),
        .i_start_req    (start_req),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_valid        (row_valid),
        .i_stall        (row_stall),
        .o_row_index    (row_index),
        .o_has_queen    (has_queen),
        .o_queen_column (queen_column),
        .o_solved       (solved),
        .o_last_row     (last_row)
    );

    always #5 clk = ~clk;

    // Depth-first search for the first placement; queues one row result per board row
    function automatic void expect_board(input logic [CfgW-1:0] size);
        int unsigned n;
        int unsigned row;
        int unsigned cand;
        int unsigned c;
        logic [MaxBoard-1:0]        col_used;
        logic [2*MaxBoard-2:0]      diag_dn;
        logic [2*MaxBoard-2:0]      diag_up;
        logic [MaxBoard-1:0][ColW-1:0] cols;
        logic                       found;
        row_report_t                rep;
        n = (size > MaxBoard) ? MaxBoard : size;
        if (n == 0) return;
        row = 0;
        cand = 0;
        col_used = '0;
        diag_dn = '0;
        diag_up = '0;
        cols = '0;
        found = 1'b0;
        forever begin
            if (row >= n) begin
                found = 1'b1;
                break;
            end
            if (cand < n) begin
                if (!col_used[cand] && !diag_dn[row + MaxBoard - 1 - cand] &&
                    !diag_up[row + cand]) begin
                    cols[row] = cand[ColW-1:0];
                    col_used[cand] = 1'b1;
                    diag_dn[row + MaxBoard - 1 - cand] = 1'b1;
                    diag_up[row + cand] = 1'b1;
                    row++;
                    cand = 0;
                end else begin
                    cand++;
                end
            end else begin
                // backtrack: lift the queen of the previous row, try its next column
                if (row == 0) break;
                row--;
                c = cols[row];
                col_used[c] = 1'b0;
                diag_dn[row + MaxBoard - 1 - c] = 1'b0;
                diag_up[row + c] = 1'b0;
                cand = c + 1;
            end
        end
        sizes_seen[n] = 1'b1;
        for (int r = 0; r < n; r++) begin
            rep.row       = r[3:0];
            rep.has_queen = found;
            rep.column    = found ? cols[r] : 4'd0;
            rep.solved    = found;
            rep.last      = (r + 1 == n);
            expected_rows.push_back(rep);
        end
    endfunction

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        if (error_count < 50)
            $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Sender: bursts of items with random gaps; an offered item holds until taken
    always @(negedge clk) begin
        logic offer;
        int   burst_left;
        int   gap_left;
        offer = 1'b0;
        if (!rst_n) begin
            offer = 1'b0;
        end else if (start_valid && !start_taken) begin
            offer = 1'b1;
        end else if (gap_left != 0) begin
            gap_left--;
        end else if (pending_starts.size() != 0) begin
            offer = 1'b1;
            start_req <= pending_starts[0];
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                                         : $urandom_range(1, 6);
            end
        end
        start_valid <= offer;
    end

    // Receiver: stall pattern in segments, plus long holds that back the block up
    always @(negedge clk) begin
        int   hold_left;
        int   seg_left;
        int   stall_mode;
        logic stall_now;
        if (hold_left != 0) begin
            hold_left--;
            stall_now = 1'b1;
        end else if (row_valid && (!first_hold_done || $urandom_range(0, 2999) == 0)) begin
            hold_left = LongHold;
            first_hold_done = 1'b1;
            long_holds++;
            stall_now = 1'b1;
        end else begin
            if (seg_left == 0) begin
                seg_left   = $urandom_range(10, 150);
                stall_mode = $urandom_range(0, 2);
            end
            seg_left--;
            case (stall_mode)
                0:       stall_now = 1'b0;
                1:       stall_now = ($urandom_range(0, 3) == 0);
                default: stall_now = ($urandom_range(0, 3) != 0);
            endcase
        end
        row_stall <= stall_now;
    end

    // Monitor: tracks the size register, predicts on each taken start, checks each row
    always @(posedge clk) begin
        logic        req;
        row_report_t want;
        start_taken <= rst_n && start_valid && !start_stall;
        if (!rst_n) begin
            size_setting = SizeRst[CfgW-1:0];
        end else begin
            if (cfg_valid && cfg_ready) size_setting = cfg_data;
            if (start_valid && !start_stall) begin
                req = pending_starts.pop_front();
                if (req) begin
                    searches_run++;
                    expect_board(size_setting);
                end else begin
                    idle_items++;
                end
            end
            if (row_valid && !row_stall) begin
                if (expected_rows.size() == 0) begin
                    report("unexpected row result, row_index", 16'(row_index), 16'hffff);
                end else begin
                    want = expected_rows.pop_front();
                    rows_checked++;
                    if (row_index !== want.row)
                        report("row_index", 16'(row_index), 16'(want.row));
                    if (has_queen !== want.has_queen)
                        report("has_queen", 16'(has_queen), 16'(want.has_queen));
                    if (queen_column !== want.column)
                        report("queen_column", 16'(queen_column), 16'(want.column));
                    if (solved !== want.solved)
                        report("solved", 16'(solved), 16'(want.solved));
                    if (last_row !== want.last)
                        report("last_row", 16'(last_row), 16'(want.last));
                end
            end
        end
    end

    // Wait until the block is idle, optionally change the board size, then queue items
    task automatic run_phase(input logic do_write, input logic [CfgW-1:0] size,
                             input logic [7:0] starts, input int count);
        do @(negedge clk); while (pending_starts.size() != 0 || expected_rows.size() != 0);
        repeat (SettleCycles) @(negedge clk);
        if (do_write) begin
            cfg_valid <= 1'b1;
            cfg_data  <= size;
            do @(posedge clk); while (!cfg_ready);
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
        @(posedge clk);
        for (int i = 0; i < count; i++) pending_starts.push_back(starts[i]);
    endtask

    initial begin
        int               pick;
        int               count;
        int               starts_queued;
        logic [CfgW-1:0]  size;
        logic [7:0]       bits;
        starts_queued = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset size with an idle item between two starts, then the corner sizes
        run_phase(1'b0, 5'd0,  8'b101, 3);
        run_phase(1'b1, 5'd1,  8'b1,   1);
        run_phase(1'b1, 5'd2,  8'b1,   1);   // no placement exists
        run_phase(1'b1, 5'd3,  8'b1,   1);   // no placement exists
        run_phase(1'b1, 5'd4,  8'b11,  2);
        run_phase(1'b1, 5'd0,  8'b01,  2);   // empty board: nothing comes back
        run_phase(1'b1, 5'd16, 8'b1,   1);
        run_phase(1'b1, 5'd31, 8'b1,   1);   // saturates to the largest board
        run_phase(1'b1, 5'd5,  8'b11,  2);
        run_phase(1'b1, 5'd13, 8'b1,   1);

        // random: mostly small boards, a few large ones with a single start each
        while (starts_queued < RandomStarts) begin
            pick = $urandom_range(0, 99);
            if (pick < 2)       size = 5'($urandom_range(17, 31));
            else if (pick < 8)  size = 5'($urandom_range(14, 15));
            else if (pick < 14) size = 5'($urandom_range(0, 3));
            else                size = 5'($urandom_range(1, 13));
            count = (size >= 14) ? 1 : $urandom_range(1, 6);
            for (int i = 0; i < 8; i++) bits[i] = ($urandom_range(0, 6) != 0);
            if (count == 1) bits[0] = 1'b1;
            run_phase(1'b1, size, bits, count);
            starts_queued += $countones(bits & ((8'h1 << count) - 8'h1));
        end

        do @(negedge clk); while (pending_starts.size() != 0 || expected_rows.size() != 0);
        repeat (SettleCycles) @(negedge clk);
        $display("covered %0d searches over %0d board sizes and %0d idle items",
                 searches_run, $countones(sizes_seen), idle_items);
        $display("%0d rows compared, %0d long output holds", rows_checked, long_holds);
        if (error_count == 0) begin
            $display("n_queens_first_solution verification clean");
        end else begin
            $display("n_queens_first_solution verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TimeoutNs);
        $display("n_queens_first_solution verification failed");
        $finish;
    end

endmodule
